FILE: src/tcc_pkg.sv
package tcc_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS);
  localparam int AddrW = $clog2(CELLS);

  // fixed field widths
  localparam int PosW  = 11;
  localparam int CellW = 16;

  // first cell of the last row and last destination cell of a scroll copy
  localparam int FillStart  = (ROWS - 1) * COLUMNS;
  localparam int ScrollLast = (ROWS - 1) * COLUMNS - 1;

  localparam logic [CellW-1:0] BLANK_CELL = 16'h0F20;

  // control codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  char_code;
    logic [3:0]  bg_color;
    logic [3:0]  fg_color;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [PosW-1:0]  cursor_pos;
    logic [CellW-1:0] cell_data;
    logic             scrolled;
  } result_t;

  // cursor update for one put-char
  typedef struct packed {
    logic            store;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            scroll;
  } step_t;

endpackage

FILE: src/tcc_cursor.sv
module tcc_cursor (
  input  logic [7:0]                char_i,
  input  logic [tcc_pkg::ColW-1:0]  col_i,
  input  logic [tcc_pkg::RowW-1:0]  row_i,
  output tcc_pkg::step_t            step_o
);
  import tcc_pkg::*;

  logic [ColW:0] col_n;
  logic [RowW:0] row_n;
  logic          store;

  // control codes, printable store and wrap
  always_comb begin
    col_n = {1'b0, col_i};
    row_n = {1'b0, row_i};
    store = 1'b0;
    unique case (char_i)
      CH_BS: begin
        if (col_i != '0) col_n = col_n - (ColW+1)'(1);
      end
      CH_TAB: begin
        col_n = col_n + (ColW+1)'(8);
        col_n[2:0] = 3'b000;
      end
      CH_CR: begin
        col_n = '0;
      end
      CH_LF: begin
        col_n = '0;
        row_n = row_n + (RowW+1)'(1);
      end
      default: begin
        if (char_i >= CH_PRINT_LO && char_i <= CH_PRINT_HI) begin
          store = 1'b1;
          col_n = col_n + (ColW+1)'(1);
        end
      end
    endcase
    if (32'(col_n) >= COLUMNS) begin
      col_n = '0;
      row_n = row_n + (RowW+1)'(1);
    end
  end

  assign step_o.store  = store;
  assign step_o.col    = col_n[ColW-1:0];
  assign step_o.row    = row_n[RowW-1:0];
  assign step_o.scroll = (32'(row_n) >= ROWS);

endmodule

FILE: src/text_console_char_writer.sv
// channel  | valid / accept         | payload
// ---------+------------------------+-----------------------------
// command  | start_i && !busy_o     | cmd_i    (tcc_pkg::cmd_t)
// result   | result_valid_o strobe  | result_o (tcc_pkg::result_t)
//
// a put or read goes through ST_EXEC (a read also through ST_RDWAIT) before
// the result; a new word is taken in the cycle the result is shown.
// a scroll walks the single cell-store write port: it copies the first
// (ROWS-1)*COLUMNS cells up one row, issues the last copy write, then makes
// COLUMNS blank writes; a clear writes all ROWS*COLUMNS cells.
// after reset a clearing pass writes all ROWS*COLUMNS cells (2000) with busy_o
// high. the receiver cannot stall: each result is shown for one cycle only.
module text_console_char_writer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tcc_pkg::cmd_t    cmd_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output tcc_pkg::result_t result_o
);
  import tcc_pkg::*;

  state_e            state_q, state_d;
  logic              init_q, init_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              cp_valid_q, cp_valid_d;
  logic [AddrW-1:0]  cp_addr_q, cp_addr_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  cmd_t              cmd_q, cmd_d;
  logic [CellW-1:0]  data_q, data_d;
  logic              scroll_q, scroll_d;

  logic [CellW-1:0]  cells_q [CELLS];
  logic [CellW-1:0]  rd_data_q;
  logic [AddrW-1:0]  rd_addr;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [CellW-1:0]  wdata;

  logic              accept;
  logic [AddrW-1:0]  pos;
  step_t             step;

  // cursor index
  assign pos = AddrW'(32'(row_q) * COLUMNS) + AddrW'(col_q);

  tcc_cursor u_cursor (
    .char_i (cmd_q.char_code),
    .col_i  (col_q),
    .row_i  (row_q),
    .step_o (step)
  );

  assign busy_o = !(state_q == ST_IDLE || state_q == ST_DONE);
  assign accept = start_i && !busy_o;

  // sequencer
  always_comb begin
    state_d    = state_q;
    init_d     = init_q;
    addr_d     = addr_q;
    cp_valid_d = 1'b0;
    cp_addr_d  = addr_q;
    col_d      = col_q;
    row_d      = row_q;
    cmd_d      = cmd_q;
    data_d     = data_q;
    scroll_d   = scroll_q;
    rd_addr    = addr_q;
    // pending copy write has the port first
    we         = cp_valid_q;
    waddr      = cp_addr_q;
    wdata      = rd_data_q;
    unique case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          data_d   = '0;
          scroll_d = 1'b0;
          state_d  = ST_EXEC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EXEC: begin
        unique case (cmd_q.func)
          FUNC_PUT: begin
            if (step.store) begin
              we    = 1'b1;
              waddr = pos;
              wdata = {cmd_q.bg_color, cmd_q.fg_color, cmd_q.char_code};
            end
            col_d = step.col;
            if (step.scroll) begin
              row_d    = RowW'(ROWS - 1);
              scroll_d = 1'b1;
              addr_d   = '0;
              state_d  = ST_SCROLL;
            end else begin
              row_d   = step.row;
              state_d = ST_DONE;
            end
          end
          FUNC_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            addr_d  = '0;
            state_d = ST_FILL;
          end
          FUNC_READ: begin
            rd_addr = AddrW'(cmd_q.cell_index);
            state_d = ST_RDWAIT;
          end
          FUNC_NOP: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SCROLL: begin
        // read one row ahead, write back on the next cycle
        rd_addr    = addr_q + AddrW'(COLUMNS);
        cp_valid_d = 1'b1;
        cp_addr_d  = addr_q;
        if (addr_q == AddrW'(ScrollLast)) begin
          addr_d  = AddrW'(FillStart);
          state_d = ST_FILL;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      ST_FILL: begin
        if (!cp_valid_q) begin
          we    = 1'b1;
          waddr = addr_q;
          wdata = BLANK_CELL;
          if (addr_q == AddrW'(CELLS - 1)) begin
            state_d = init_q ? ST_IDLE : ST_DONE;
            init_d  = 1'b0;
          end else begin
            addr_d = addr_q + AddrW'(1);
          end
        end
      end
      ST_RDWAIT: begin
        data_d  = (32'(cmd_q.cell_index) < CELLS) ? rd_data_q : '0;
        state_d = ST_DONE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      init_q     <= 1'b1;
      addr_q     <= '0;
      cp_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      scroll_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      addr_q     <= addr_d;
      cp_valid_q <= cp_valid_d;
      col_q      <= col_d;
      row_q      <= row_d;
      scroll_q   <= scroll_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cp_addr_q <= cp_addr_d;
    cmd_q     <= cmd_d;
    data_q    <= data_d;
  end

  // cell store
  always_ff @(posedge clk_i) begin
    if (we) cells_q[waddr] <= wdata;
    rd_data_q <= cells_q[rd_addr];
  end

  assign result_valid_o      = (state_q == ST_DONE);
  assign result_o.cursor_pos = PosW'(pos);
  assign result_o.cell_data  = data_q;
  assign result_o.scrolled   = scroll_q;

endmodule

FILE: src/tcc_checker.sv
module tcc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input tcc_pkg::cmd_t    cmd_i,
  input logic             busy_o,
  input logic             result_valid_o,
  input tcc_pkg::result_t result_o
);
  import tcc_pkg::*;

  // an accepted word always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accepted word");

  // results are single-cycle strobes
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held two cycles");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (32'(result_o.cursor_pos) < CELLS))
    else $error("cursor off screen");

  // a scroll leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.scrolled) |-> (32'(result_o.cursor_pos) >= FillStart))
    else $error("scroll left cursor above last row");

  // scroll and cell read never share a result
  a_scroll_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.scrolled) |-> (result_o.cell_data == '0))
    else $error("scroll result carries cell data");

endmodule

bind text_console_char_writer tcc_checker u_tcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .cmd_i          (cmd_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
